@@ rtl/bfc_pkg.sv @@
`default_nettype none

package bfc_pkg;

   localparam int COORD_BITS_DEF  = 16;
   localparam int NORMAL_BITS_DEF = 12;

   localparam int CSR_DATA_BITS  = 64;
   localparam int CSR_INDEX_BITS = 3;
   localparam int EXTRA_BITS     = 48;
   localparam int MODE_BITS      = 3;

   // origin and radius fields of far_word in radial mode
   localparam int ORIGIN_BITS = 16;
   localparam int RADIUS_LSB  = 48;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_SIDE_PLANE_0  = 3'd0,
      CSR_SIDE_PLANE_1  = 3'd1,
      CSR_SIDE_PLANE_2  = 3'd2,
      CSR_SIDE_PLANE_3  = 3'd3,
      CSR_FAR_WORD      = 3'd4,
      CSR_EXTRA_BOX_LOW = 3'd5,
      CSR_EXTRA_BOX_HI  = 3'd6,
      CSR_CULL_MODE     = 3'd7
   } csr_index_type;

   typedef enum logic [1:0] {
      FAR_OFF    = 2'd0,
      FAR_DEPTH  = 2'd1,
      FAR_RADIAL = 2'd2,
      FAR_OFF_3  = 2'd3
   } far_mode_type;

   // load enables of the plane pipeline stages
   typedef struct packed {
      logic load_prod;
      logic load_sum;
   } stage_en_type;

endpackage

`default_nettype wire

@@ rtl/bfc_plane_dot.sv @@
`default_nettype none

module bfc_plane_dot #(
   parameter int COORD_BITS  = bfc_pkg::COORD_BITS_DEF,
   parameter int NORMAL_BITS = bfc_pkg::NORMAL_BITS_DEF
) (
   input  wire logic                          clock,
   input  wire bfc_pkg::stage_en_type         stage_en,
   input  wire logic [63:0]                   plane,
   input  wire logic [3*COORD_BITS-1:0]       box_lo,
   input  wire logic [3*COORD_BITS-1:0]       box_hi,
   output logic                               behind
);
   import bfc_pkg::*;

   localparam int DB = 64 - 3 * NORMAL_BITS;
   localparam int PW = NORMAL_BITS + COORD_BITS;
   localparam int SW = PW + 2;
   localparam int CW = ((SW > DB) ? SW : DB) + 1;

   logic signed [NORMAL_BITS-1:0] nrm    [3];
   logic signed [COORD_BITS-1:0]  corner [3];
   logic signed [PW-1:0]          prod_in [3];
   logic signed [PW-1:0]          prod_ff [3];
   logic signed [SW-1:0]          sum_in;
   logic signed [SW-1:0]          sum_ff;
   logic signed [DB-1:0]          plane_dist;

   // farthest corner along the normal: min coordinate for negative components
   always_comb begin
      for (int j = 0; j < 3; j++) begin
         nrm[j]     = plane[j*NORMAL_BITS +: NORMAL_BITS];
         corner[j]  = nrm[j][NORMAL_BITS-1] ? box_lo[j*COORD_BITS +: COORD_BITS]
                                            : box_hi[j*COORD_BITS +: COORD_BITS];
         prod_in[j] = PW'(nrm[j]) * PW'(corner[j]);
      end
   end

   assign sum_in     = SW'(prod_ff[0]) + SW'(prod_ff[1]) + SW'(prod_ff[2]);
   assign plane_dist = plane[63:3*NORMAL_BITS];
   assign behind     = CW'(sum_ff) < CW'(plane_dist);

   always_ff @(posedge clock) begin
      if (stage_en.load_prod) begin
         prod_ff <= prod_in;
      end
      if (stage_en.load_sum) begin
         sum_ff <= sum_in;
      end
   end

endmodule

`default_nettype wire

@@ rtl/box_frustum_cull_test.sv @@
`default_nettype none

// Box frustum cull test. One axis-aligned box (min and max corner) enters per
// req word and one rsp word returns per box, bit 0 set when the box is culled.
// A box is culled when the enabled extra box misses it, when the far test
// (depth plane or radial cube) rejects it, or when one of the four side planes
// has it wholly behind. Throughput is one box per cycle while rsp is not stalled;
// a box passes through the input register, normal-sign corner select and
// multiply, three-term dot sum, then distance compare into the rsp register.
// The five planes each own three multipliers, so nothing is shared between
// planes. Each stage holds its own valid bit and fills bubbles while rsp is
// stalled. Registers are written through the csr port, which is always ready;
// write them only while no box is in flight.
module box_frustum_cull_test #(
   parameter int COORD_BITS  = bfc_pkg::COORD_BITS_DEF,
   parameter int NORMAL_BITS = bfc_pkg::NORMAL_BITS_DEF
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   // req_tdata: min_x, min_y, min_z, max_x, max_y, max_z (low bits first)
   input  wire logic                                 req_tvalid,
   output logic                                      req_tready,
   input  wire logic [((6*COORD_BITS+7)/8)*8-1:0]    req_tdata,
   // rsp_tdata: culled
   output logic                                      rsp_tvalid,
   input  wire logic                                 rsp_tready,
   output logic [7:0]                                rsp_tdata,
   input  wire logic                                 csr_valid,
   output logic                                      csr_ready,
   input  wire logic [bfc_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  wire logic [bfc_pkg::CSR_DATA_BITS-1:0]    csr_data
);
   import bfc_pkg::*;

   localparam int CB  = COORD_BITS;
   localparam int EXW = (3 * CB > EXTRA_BITS) ? 3 * CB : EXTRA_BITS;
   localparam int RW  = ((CB > ORIGIN_BITS + 2) ? CB : ORIGIN_BITS + 2) + 1;
   localparam int NPLANE = 5;

   // configuration registers
   logic [63:0]           side_plane_ff [4];
   logic [63:0]           far_word_ff;
   logic [EXTRA_BITS-1:0] extra_lo_ff;
   logic [EXTRA_BITS-1:0] extra_hi_ff;
   logic [MODE_BITS-1:0]  cull_mode_ff;

   far_mode_type far_mode;
   logic         extra_en;

   // pipeline valid bits and ready chain
   logic v0_ff, v1_ff, v2_ff, v3_ff;
   logic rdy0, rdy1, rdy2, rdy3;

   // stage 0: box registers
   logic [3*CB-1:0] box_lo_ff, box_hi_ff;

   // stage 1 and 2: box-overlap flags
   logic extra_apart_in, radial_apart_in;
   logic extra_apart_ff, radial_apart_ff;
   logic apart_s2_ff;

   // stage 3: result
   logic culled_in, culled_ff;

   logic [EXW-1:0]   extra_lo_ext, extra_hi_ext;
   logic [63:0]      plane_word [NPLANE];
   logic [NPLANE-1:0] behind;
   stage_en_type     stage_en;

   // ---------------- configuration write ----------------
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 4; i++) begin
            side_plane_ff[i] <= '0;
         end
         far_word_ff  <= '0;
         extra_lo_ff  <= '0;
         extra_hi_ff  <= '0;
         cull_mode_ff <= '0;
      end else if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_SIDE_PLANE_0:  side_plane_ff[0] <= csr_data;
            CSR_SIDE_PLANE_1:  side_plane_ff[1] <= csr_data;
            CSR_SIDE_PLANE_2:  side_plane_ff[2] <= csr_data;
            CSR_SIDE_PLANE_3:  side_plane_ff[3] <= csr_data;
            CSR_FAR_WORD:      far_word_ff      <= csr_data;
            CSR_EXTRA_BOX_LOW: extra_lo_ff      <= csr_data[EXTRA_BITS-1:0];
            CSR_EXTRA_BOX_HI:  extra_hi_ff      <= csr_data[EXTRA_BITS-1:0];
            CSR_CULL_MODE:     cull_mode_ff     <= csr_data[MODE_BITS-1:0];
            default: ;
         endcase
      end
   end

   assign far_mode = far_mode_type'(cull_mode_ff[1:0]);
   assign extra_en = cull_mode_ff[2];

   // ---------------- handshake ----------------
   // a stage loads when it is empty or the stage after it moves on
   assign rdy3 = !v3_ff || rsp_tready;
   assign rdy2 = !v2_ff || rdy3;
   assign rdy1 = !v1_ff || rdy2;
   assign rdy0 = !v0_ff || rdy1;

   assign req_tready = rdy0;
   assign rsp_tvalid = v3_ff;
   assign rsp_tdata  = {7'b0, culled_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (rdy0) v0_ff <= req_tvalid;
         if (rdy1) v1_ff <= v0_ff;
         if (rdy2) v2_ff <= v1_ff;
         if (rdy3) v3_ff <= v2_ff;
      end
   end

   // ---------------- stage 0: capture box ----------------
   always_ff @(posedge clock) begin
      if (rdy0) begin
         box_lo_ff <= req_tdata[3*CB-1:0];
         box_hi_ff <= req_tdata[6*CB-1:3*CB];
      end
   end

   // ---------------- stage 1: overlap tests ----------------
   // extra box fields beyond the 48-bit register read as zero
   assign extra_lo_ext = EXW'(extra_lo_ff);
   assign extra_hi_ext = EXW'(extra_hi_ff);

   always_comb begin
      logic signed [CB-1:0] blo, bhi, elo, ehi;
      logic signed [ORIGIN_BITS-1:0] org;
      logic signed [RW-1:0] clo, chi, rad;
      extra_apart_in  = 1'b0;
      radial_apart_in = 1'b0;
      rad = RW'({1'b0, far_word_ff[RADIUS_LSB +: ORIGIN_BITS]});
      for (int j = 0; j < 3; j++) begin
         blo = box_lo_ff[j*CB +: CB];
         bhi = box_hi_ff[j*CB +: CB];
         elo = extra_lo_ext[j*CB +: CB];
         ehi = extra_hi_ext[j*CB +: CB];
         if (elo > bhi || ehi < blo) begin
            extra_apart_in = 1'b1;
         end
         // radial cube bounds at full width, no wrap
         org = far_word_ff[j*ORIGIN_BITS +: ORIGIN_BITS];
         clo = RW'(org) - rad;
         chi = RW'(org) + rad;
         if (clo > RW'(bhi) || chi < RW'(blo)) begin
            radial_apart_in = 1'b1;
         end
      end
      extra_apart_in  = extra_apart_in && extra_en;
      radial_apart_in = radial_apart_in && (far_mode == FAR_RADIAL);
   end

   always_ff @(posedge clock) begin
      if (rdy1) begin
         extra_apart_ff  <= extra_apart_in;
         radial_apart_ff <= radial_apart_in;
      end
      if (rdy2) begin
         apart_s2_ff <= extra_apart_ff || radial_apart_ff;
      end
   end

   // ---------------- planes: multiply in stage 1, sum in stage 2 ----------------
   assign stage_en.load_prod = rdy1;
   assign stage_en.load_sum  = rdy2;

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         plane_word[i] = side_plane_ff[i];
      end
      plane_word[4] = far_word_ff;
   end

   for (genvar p = 0; p < NPLANE; p++) begin : g_plane
      bfc_plane_dot #(
         .COORD_BITS  (COORD_BITS),
         .NORMAL_BITS (NORMAL_BITS)
      ) u_plane (
         .clock    (clock),
         .stage_en (stage_en),
         .plane    (plane_word[p]),
         .box_lo   (box_lo_ff),
         .box_hi   (box_hi_ff),
         .behind   (behind[p])
      );
   end

   // ---------------- stage 3: combine into rsp register ----------------
   assign culled_in = apart_s2_ff || (|behind[3:0]) ||
                      (behind[4] && (far_mode == FAR_DEPTH));

   always_ff @(posedge clock) begin
      if (rdy3) begin
         culled_ff <= culled_in;
      end
   end

endmodule

`default_nettype wire

@@ rtl/bfc_checker.sv @@
`default_nettype none

module bfc_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_tvalid,
   input wire logic       req_tready,
   input wire logic       rsp_tvalid,
   input wire logic       rsp_tready,
   input wire logic [7:0] rsp_tdata
);

   logic       req_acc, rsp_acc;
   logic [2:0] pend_ff, pend_in;

   assign req_acc = req_tvalid && req_tready;
   assign rsp_acc = rsp_tvalid && rsp_tready;
   assign pend_in = pend_ff + {2'b0, req_acc} - {2'b0, rsp_acc};

   // boxes in flight
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
      end else begin
         pend_ff <= pend_in;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("rsp word dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata))
      else $error("rsp word changed while stalled");

   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> pend_ff != 3'd0)
      else $error("rsp word without a pending box");

   a_depth: assert property (@(posedge clock) disable iff (reset)
      pend_ff <= 3'd4)
      else $error("more boxes in flight than pipeline stages");

endmodule

bind box_frustum_cull_test bfc_checker u_bfc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire

@@ bench/cull_check_pkg.sv @@
`timescale 1ns / 100ps

package cull_check_pkg;
   import bfc_pkg::*;

   localparam int CB = COORD_BITS_DEF;
   localparam int NB = NORMAL_BITS_DEF;
   localparam int DB = CSR_DATA_BITS - 3 * NB;

   // one req word, min_x in the low bits
   typedef struct packed {
      logic signed [CB-1:0] max_z;
      logic signed [CB-1:0] max_y;
      logic signed [CB-1:0] max_x;
      logic signed [CB-1:0] min_z;
      logic signed [CB-1:0] min_y;
      logic signed [CB-1:0] min_x;
   } box_word_t;

   class cull_scoreboard;
      logic [CSR_DATA_BITS-1:0] side_plane [4];
      logic [CSR_DATA_BITS-1:0] far_word;
      logic [EXTRA_BITS-1:0]    extra_lo;
      logic [EXTRA_BITS-1:0]    extra_hi;
      logic [MODE_BITS-1:0]     mode;
      bit                       verdict_q [$];
      int                       errors;
      int                       boxes;
      int                       results;
      int                       culled;

      function new();
         foreach (side_plane[i]) side_plane[i] = '0;
         far_word = '0;
         extra_lo = '0;
         extra_hi = '0;
         mode     = '0;
         errors   = 0;
         boxes    = 0;
         results  = 0;
         culled   = 0;
      endfunction

      function void write_reg(csr_index_type idx, logic [CSR_DATA_BITS-1:0] v);
         case (idx) inside
            CSR_SIDE_PLANE_0, CSR_SIDE_PLANE_1,
            CSR_SIDE_PLANE_2, CSR_SIDE_PLANE_3: side_plane[int'(idx)] = v;
            CSR_FAR_WORD:      far_word = v;
            CSR_EXTRA_BOX_LOW: extra_lo = v[EXTRA_BITS-1:0];
            CSR_EXTRA_BOX_HI:  extra_hi = v[EXTRA_BITS-1:0];
            CSR_CULL_MODE:     mode = v[MODE_BITS-1:0];
            default: ;
         endcase
      endfunction

      // farthest corner along the normal still short of the distance
      static function bit behind_plane(logic [CSR_DATA_BITS-1:0] p,
                                       longint lo [3], longint hi [3]);
         longint dot;
         longint n;
         longint plane_dist;
         dot        = 0;
         plane_dist = longint'($signed(p[CSR_DATA_BITS-1 -: DB]));
         for (int j = 0; j < 3; j++) begin
            n = longint'($signed(p[j*NB +: NB]));
            dot += n * ((n < 0) ? lo[j] : hi[j]);
         end
         return dot < plane_dist;
      endfunction

      static function bit boxes_apart(longint alo [3], longint ahi [3],
                                      longint blo [3], longint bhi [3]);
         for (int j = 0; j < 3; j++) begin
            if (alo[j] > bhi[j] || ahi[j] < blo[j]) return 1'b1;
         end
         return 1'b0;
      endfunction

      function bit cull_verdict(box_word_t b);
         longint       lo [3];
         longint       hi [3];
         longint       elo [3];
         longint       ehi [3];
         longint       clo [3];
         longint       chi [3];
         longint       radius;
         longint       o;
         bit           cut;
         far_mode_type fm;
         lo[0] = b.min_x; lo[1] = b.min_y; lo[2] = b.min_z;
         hi[0] = b.max_x; hi[1] = b.max_y; hi[2] = b.max_z;
         cut = 1'b0;
         fm  = far_mode_type'(mode[1:0]);
         if (mode[2]) begin
            for (int j = 0; j < 3; j++) begin
               elo[j] = longint'($signed(extra_lo[j*CB +: CB]));
               ehi[j] = longint'($signed(extra_hi[j*CB +: CB]));
            end
            if (boxes_apart(elo, ehi, lo, hi)) cut = 1'b1;
         end
         case (fm)
            FAR_DEPTH: begin
               if (behind_plane(far_word, lo, hi)) cut = 1'b1;
            end
            FAR_RADIAL: begin
               // cube bounds kept at full width, no wrap
               radius = longint'(far_word[RADIUS_LSB +: 16]);
               for (int j = 0; j < 3; j++) begin
                  o      = longint'($signed(far_word[j*ORIGIN_BITS +: ORIGIN_BITS]));
                  clo[j] = o - radius;
                  chi[j] = o + radius;
               end
               if (boxes_apart(clo, chi, lo, hi)) cut = 1'b1;
            end
            default: ;  // off, spare code included
         endcase
         for (int j = 0; j < 4; j++) begin
            if (behind_plane(side_plane[j], lo, hi)) cut = 1'b1;
         end
         return cut;
      endfunction

      function void note_box(box_word_t b);
         verdict_q.push_back(cull_verdict(b));
         boxes++;
      endfunction

      task report(string what);
         $display("[%0t] mismatch: %s", $time, what);
         errors++;
      endtask

      task check_result(logic [7:0] w);
         bit want;
         results++;
         if (verdict_q.size() == 0) begin
            report($sformatf("rsp word %h with no box outstanding", w));
            return;
         end
         want = verdict_q.pop_front();
         if (w[0] !== want)
            report($sformatf("result %0d: culled %b, predicted %b", results, w[0], want));
         if (w[0] === 1'b1) culled++;
      endtask

      function int pending();
         return verdict_q.size();
      endfunction
   endclass

endpackage

@@ bench/box_frustum_cull_test_test.sv @@
`timescale 1ns / 100ps

// Drives boxes through the cull block under a series of register settings and
// checks every rsp word against the scoreboard's own cull prediction.
module box_frustum_cull_test_test;
   import bfc_pkg::*;
   import cull_check_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;   // cycles with no handshake at all
   localparam int DRAIN_CYCLES   = 8;      // pipe is four deep

   logic                          clock       = 1'b0;
   logic                          reset       = 1'b1;
   logic                          req_tvalid  = 1'b0;
   logic                          req_tready;
   box_word_t                     req_tdata   = '0;
   logic                          rsp_tvalid;
   logic                          rsp_tready  = 1'b0;
   logic [7:0]                    rsp_tdata;
   logic                          csr_valid   = 1'b0;
   logic                          csr_ready;
   csr_index_type                 csr_index   = CSR_SIDE_PLANE_0;
   logic [CSR_DATA_BITS-1:0]      csr_data    = '0;

   cull_scoreboard sb;
   bit             quiet        = 1'b0;   // final stretch: no idling on either side
   int             req_idle_pct = 0;
   int             rsp_idle_pct = 0;
   int             rsp_hold     = 0;
   int             idle_cycles  = 0;
   int             settings     = 0;

   csr_index_type  side_idx [4] = '{CSR_SIDE_PLANE_0, CSR_SIDE_PLANE_1,
                                    CSR_SIDE_PLANE_2, CSR_SIDE_PLANE_3};

   always #10 clock = ~clock;

   box_frustum_cull_test dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   // ---------------------------------------------------------------------
   // Receiver: random stall bursts, driven on the falling edge
   // ---------------------------------------------------------------------
   always @(negedge clock) begin
      if (rsp_hold > 0) begin
         rsp_hold = rsp_hold - 1;
         rsp_tready <= 1'b0;
      end else if (!quiet && $urandom_range(1, 100) <= rsp_idle_pct) begin
         rsp_hold = $urandom_range(0, 6);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // every rsp word is checked against the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata);
   end

   // watchdog: no word moving on any channel for too long
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Watchdog: no handshake for %0d cycles, %0d results outstanding",
                  idle_cycles, sb.pending());
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // ---------------------------------------------------------------------
   // Value builders
   // ---------------------------------------------------------------------
   function automatic logic [CB-1:0] c16(int v);
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      return v[CB-1:0];
   endfunction

   function automatic int srand(int span);
      return int'($urandom_range(0, 2 * span)) - span;
   endfunction

   function automatic box_word_t mk_box(int x0, int y0, int z0, int x1, int y1, int z1);
      box_word_t b;
      b.min_x = c16(x0); b.min_y = c16(y0); b.min_z = c16(z0);
      b.max_x = c16(x1); b.max_y = c16(y1); b.max_z = c16(z1);
      return b;
   endfunction

   // normals Q1.10 low, distance in the top bits
   function automatic logic [CSR_DATA_BITS-1:0] plane_word(int nx, int ny, int nz,
                                                           longint plane_dist);
      logic [CSR_DATA_BITS-1:0] w;
      w[NB-1:0]              = nx[NB-1:0];
      w[2*NB-1:NB]           = ny[NB-1:0];
      w[3*NB-1:2*NB]         = nz[NB-1:0];
      w[CSR_DATA_BITS-1:3*NB] = plane_dist[DB-1:0];
      return w;
   endfunction

   function automatic logic [CSR_DATA_BITS-1:0] mode_word(bit extra_on, far_mode_type fm);
      return {61'b0, extra_on, fm};
   endfunction

   // mix of never-culling, axis-aligned, oblique and fully random planes
   function automatic logic [CSR_DATA_BITS-1:0] rand_plane();
      int nrm [3];
      int axis;
      int bound;
      case ($urandom_range(0, 7)) inside
         0: return plane_word(0, 0, 0, -longint'($urandom_range(1, 1 << 20)));
         [1:3]: begin
            nrm = '{0, 0, 0};
            axis = $urandom_range(0, 2);
            nrm[axis] = $urandom_range(0, 1) ? 1024 : -1024;
            bound = $urandom_range(0, 7000);
            return plane_word(nrm[0], nrm[1], nrm[2],
                              -longint'(bound) * 1024 - longint'($urandom_range(0, 1023)));
         end
         [4:6]: return plane_word(srand(1024), srand(1024), srand(1024),
                                  -longint'($urandom_range(0, 1 << 23)));
         default: return {$urandom, $urandom};
      endcase
   endfunction

   function automatic logic [CSR_DATA_BITS-1:0] rand_radial();
      logic [15:0] rad;
      rad = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(500, 12000));
      return {rad, c16(srand(4000)), c16(srand(4000)), c16(srand(4000))};
   endfunction

   // upper 16 bits carry junk; the block keeps only 48
   function automatic void rand_extra(output logic [CSR_DATA_BITS-1:0] lo,
                                      output logic [CSR_DATA_BITS-1:0] hi);
      int a [3];
      int b [3];
      if ($urandom_range(0, 5) == 0) begin
         lo = {$urandom, $urandom};
         hi = {$urandom, $urandom};
      end else begin
         for (int j = 0; j < 3; j++) begin
            a[j] = srand(5000);
            b[j] = a[j] + int'($urandom_range(0, 10000));
         end
         lo = {16'($urandom), c16(a[2]), c16(a[1]), c16(a[0])};
         hi = {16'($urandom), c16(b[2]), c16(b[1]), c16(b[0])};
      end
   endfunction

   // occasionally force a register to all zeros or all ones
   function automatic logic [CSR_DATA_BITS-1:0] maybe_edge(logic [CSR_DATA_BITS-1:0] v);
      case ($urandom_range(0, 15))
         0: return '0;
         1: return '1;
         default: return v;
      endcase
   endfunction

   function automatic int edge_coord();
      case ($urandom_range(0, 3))
         0: return -32768;
         1: return 32767;
         2: return 0;
         default: return srand(32767);
      endcase
   endfunction

   // mostly well-formed boxes near the view volume; some noise, inverted, extreme
   function automatic box_word_t rand_box();
      box_word_t b;
      int        kind;
      int        span;
      int        c;
      int        h;
      int        lo [3];
      int        hi [3];
      kind = $urandom_range(0, 19);
      if (kind >= 14 && kind < 17) begin
         b = {$urandom, $urandom, $urandom};
         return b;
      end
      for (int j = 0; j < 3; j++) begin
         if (kind < 14) begin
            span  = (kind < 10) ? 4000 : 16000;
            c     = srand(span);
            h     = $urandom_range(0, span / 4);
            lo[j] = c - h;
            hi[j] = c + h;
         end else if (kind < 19) begin
            c     = srand(4000);
            h     = $urandom_range(1, 2000);
            lo[j] = c + h;
            hi[j] = c - h;
         end else begin
            lo[j] = edge_coord();
            hi[j] = edge_coord();
         end
      end
      return mk_box(lo[0], lo[1], lo[2], hi[0], hi[1], hi[2]);
   endfunction

   // ---------------------------------------------------------------------
   // Channel tasks
   // ---------------------------------------------------------------------
   // valid stays high across back-to-back words; an idle gap drops it between words
   task automatic send_box(input box_word_t b);
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      do @(posedge clock); while (!req_tready);
      sb.note_box(b);
      if (!quiet && $urandom_range(1, 100) <= req_idle_pct) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
         repeat ($urandom_range(0, 6)) @(negedge clock);
      end
   endtask

   task automatic end_stream();
      @(negedge clock);
      req_tvalid <= 1'b0;
   endtask

   task automatic csr_write(input csr_index_type idx, input logic [CSR_DATA_BITS-1:0] v);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= v;
      do @(posedge clock); while (!csr_ready);
      sb.write_reg(idx, v);
   endtask

   task automatic csr_done();
      @(negedge clock);
      csr_valid <= 1'b0;
      settings++;
   endtask

   // stop sending, let every result come back, then give the pipe time to empty
   task automatic settle();
      end_stream();
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // ---------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------
   initial begin
      logic [CSR_DATA_BITS-1:0] elo;
      logic [CSR_DATA_BITS-1:0] ehi;
      far_mode_type             fm;

      sb = new();
      repeat (4) @(negedge clock);
      reset <= 1'b0;

      // registers at reset: nothing may be culled
      req_idle_pct = 20;
      rsp_idle_pct = 15;
      send_box(mk_box(0, 0, 0, 0, 0, 0));
      send_box(mk_box(-32768, -32768, -32768, 32767, 32767, 32767));
      send_box(mk_box(32767, 32767, 32767, -32768, -32768, -32768));
      settle();

      // four axis planes at +-1000, depth plane at z = 2000
      csr_write(CSR_SIDE_PLANE_0, plane_word(1024, 0, 0, -1000 * 1024));
      csr_write(CSR_SIDE_PLANE_1, plane_word(-1024, 0, 0, -1000 * 1024));
      csr_write(CSR_SIDE_PLANE_2, plane_word(0, -1024, 0, -1000 * 1024));
      csr_write(CSR_SIDE_PLANE_3, plane_word(0, 1024, 0, -1000 * 1024));
      csr_write(CSR_FAR_WORD, plane_word(0, 0, -1024, -2000 * 1024));
      csr_write(CSR_CULL_MODE, mode_word(1'b0, FAR_DEPTH));
      csr_done();
      send_box(mk_box(-10, -10, -10, 10, 10, 10));
      send_box(mk_box(-1200, 0, 0, -1001, 10, 10));     // left of left plane
      send_box(mk_box(-1200, 0, 0, -1000, 10, 10));     // touches it: kept
      send_box(mk_box(1001, 0, 0, 1200, 10, 10));
      send_box(mk_box(0, 1001, 0, 10, 1200, 10));
      send_box(mk_box(0, -1200, 0, 10, -1001, 10));
      send_box(mk_box(0, 0, 2001, 10, 10, 2100));       // past far plane
      send_box(mk_box(0, 0, 2000, 10, 10, 2100));       // on far plane: kept
      send_box(mk_box(500, 500, 500, -500, -500, -500)); // inverted
      settle();

      // radial cube around (100,-200,300) radius 500, extra box +-300
      foreach (side_idx[i]) csr_write(side_idx[i], '0);
      csr_write(CSR_FAR_WORD, {16'd500, c16(300), c16(-200), c16(100)});
      csr_write(CSR_EXTRA_BOX_LOW, {16'h0, c16(-300), c16(-300), c16(-300)});
      csr_write(CSR_EXTRA_BOX_HI, {16'h0, c16(300), c16(300), c16(300)});
      csr_write(CSR_CULL_MODE, mode_word(1'b1, FAR_RADIAL));
      csr_done();
      send_box(mk_box(-10, -10, -10, 10, 10, 10));
      send_box(mk_box(0, 0, -300, 10, 10, -250));       // below the cube only
      send_box(mk_box(400, 0, 0, 500, 10, 10));         // outside the extra box only
      send_box(mk_box(300, 0, 0, 350, 10, 10));         // touches extra box edge
      send_box(mk_box(200, 200, 200, -200, -200, -200));
      settle();

      // all-ones planes, widest radial cube (no wrap), extra box all ones but off
      foreach (side_idx[i]) csr_write(side_idx[i], '1);
      csr_write(CSR_FAR_WORD, 64'hFFFF_8000_8000_8000);
      csr_write(CSR_EXTRA_BOX_LOW, '1);
      csr_write(CSR_EXTRA_BOX_HI, '1);
      csr_write(CSR_CULL_MODE, mode_word(1'b0, FAR_RADIAL));
      csr_done();
      send_box(mk_box(0, 0, 0, 5, 5, 5));
      send_box(mk_box(1, 1, 0, 5, 5, 5));
      send_box(mk_box(-32768, -32768, -32768, 32767, 32767, 32767));
      settle();

      // spare far code: a cull-everything depth plane must be ignored
      foreach (side_idx[i]) csr_write(side_idx[i], '0);
      csr_write(CSR_FAR_WORD, 64'h7FFF_FFF0_0000_0000);
      csr_write(CSR_EXTRA_BOX_LOW, 64'hABCD_FFFF_FFFF_FFFF);
      csr_write(CSR_EXTRA_BOX_HI, 64'h1234_0000_0000_0000);
      csr_write(CSR_CULL_MODE, mode_word(1'b1, FAR_OFF_3));
      csr_done();
      send_box(mk_box(0, 0, 0, 0, 0, 0));
      send_box(mk_box(1, 0, 0, 5, 5, 5));
      send_box(mk_box(-5, -5, -5, -1, -1, -1));
      settle();

      // random settings; the last two run with no idling at all
      for (int ph = 0; ph < 9; ph++) begin
         quiet        = (ph >= 7);
         req_idle_pct = (quiet || ph == 2) ? 0 : $urandom_range(10, 50);
         rsp_idle_pct = (quiet || ph == 4) ? 0 : $urandom_range(5, 25);
         foreach (side_idx[i]) csr_write(side_idx[i], maybe_edge(rand_plane()));
         fm = far_mode_type'($urandom_range(FAR_OFF, FAR_OFF_3));
         if ((fm == FAR_RADIAL) != ($urandom_range(0, 4) == 0))
            csr_write(CSR_FAR_WORD, maybe_edge(rand_radial()));
         else
            csr_write(CSR_FAR_WORD, maybe_edge(rand_plane()));
         rand_extra(elo, ehi);
         csr_write(CSR_EXTRA_BOX_LOW, maybe_edge(elo));
         csr_write(CSR_EXTRA_BOX_HI, maybe_edge(ehi));
         csr_write(CSR_CULL_MODE, mode_word(1'($urandom_range(0, 1)), fm));
         csr_done();
         for (int k = 0; k < 55; k++) begin
            if (ph == 3 && k == 25) begin
               // hold the sender until every outstanding result is back
               end_stream();
               while (sb.pending() != 0) @(posedge clock);
            end
            send_box(rand_box());
         end
         settle();
      end

      $display("Covered %0d boxes under %0d register settings: %0d culled, %0d kept",
               sb.boxes, settings, sb.culled, sb.results - sb.culled);
      $display("Far modes off, depth, radial and spare; extra box on and off; random stalls");
      if (sb.errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
